@@ hdl/lane_edge_row_scanner_unit_macros.svh @@
// Assertion macros for the lane edge row scanner.
// Included by the top level; defining ASSERT_OFF removes every check.
`ifndef LANE_EDGE_ROW_SCANNER_UNIT_MACROS_SVH
`define LANE_EDGE_ROW_SCANNER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LERS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LERS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LERS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LERS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hdl/lers_pkg.sv @@
// Types and constants of the lane edge row scanner.
// No dependencies; used by the top level and the bench.
`default_nettype none

package lers_pkg;

   typedef logic signed [9:0] win_type;

   typedef enum logic [1:0] {
      KIND_LEFT    = 2'd0,
      KIND_RIGHT   = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CSR_ROI_LEFT   = 3'd0,
      CSR_ROI_WIDTH  = 3'd1,
      CSR_PAD_WIDTH  = 3'd2,
      CSR_THRESHOLD  = 3'd3,
      CSR_MIN_POINTS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] column;
      logic [7:0] row;
      logic       row_end;
      logic       frame_start;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] edge_column;
      logic [7:0] edge_row;
      logic [7:0] left_total;
      logic [7:0] right_total;
      logic       enough_points;
      logic       last;
   } rsp_word_type;

   // columns at or past this limit never hit
   localparam int unsigned ColumnLimit = 256;
   localparam int unsigned ResultSlots = 3;

   localparam logic [7:0] RoiLeftReset   = 8'd0;
   localparam logic [8:0] RoiWidthReset  = 9'd256;
   localparam logic [5:0] PadWidthReset  = 6'd10;
   localparam logic [7:0] ThresholdReset = 8'd128;
   localparam logic [7:0] MinPointsReset = 8'd10;

   // windows derived from the register reset values
   localparam win_type LeftStartReset  = 10'sd118;
   localparam win_type LeftEndReset    = 10'sd10;
   localparam win_type RightStartReset = 10'sd138;
   localparam win_type RightEndReset   = 10'sd245;

endpackage

`default_nettype wire

@@ hdl/lers_word_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; instantiated with lers_pkg word types.
`default_nettype none

interface lers_word_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/lane_edge_row_scanner_unit.sv @@
// Lane edge row scanner: per-pixel window search, row-end edge points, frame summary.
// Depends on lers_pkg, lers_word_if and lane_edge_row_scanner_unit_macros.svh.
//
//   channel   dir  payload                 handshake
//   req_chan  in   lers_pkg::req_word_type  valid/ready
//   rsp_chan  out  lers_pkg::rsp_word_type  valid/ready
//   csr_*     in   index 3b, data 9b        write enable, no stall
//
// A pixel word is processed in the cycle it is accepted; its results sit in a
// three-slot result bank from the next cycle on and leave one per cycle while
// rsp_chan is ready. A new word is taken while the bank holds at most one
// result being taken, so pixels stream at one per cycle while results drain;
// a word closing a row or frame with two or three results holds the input until they drain.
// Reset is synchronous: configuration, scan state and result count go to their reset values, windows follow them.
`default_nettype none
`include "lane_edge_row_scanner_unit_macros.svh"

module lane_edge_row_scanner_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   lers_word_if.sink         req_chan,
   lers_word_if.source       rsp_chan,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [8:0]   csr_wdata
);

   // configuration registers
   logic [7:0] roi_left_ff, roi_left_in;
   logic [8:0] roi_width_ff, roi_width_in;
   logic [5:0] pad_ff, pad_in;
   logic [7:0] thresh_ff, thresh_in;
   logic [7:0] min_ff, min_in;

   // scan state
   lers_pkg::win_type ls_ff, ls_in, le_ff, le_in, rs_ff, rs_in, re_ff, re_in;
   logic       ldone_ff, ldone_in, rdone_ff, rdone_in;
   logic       lhv_ff, lhv_in, rhv_ff, rhv_in;
   logic [7:0] lhc_ff, lhc_in, rhc_ff, rhc_in;
   logic [7:0] lc_ff, lc_in, rc_ff, rc_in;

   // result bank, slot 0 is presented
   lers_pkg::rsp_word_type res_ff [lers_pkg::ResultSlots];
   lers_pkg::rsp_word_type res_in [lers_pkg::ResultSlots];
   logic [1:0] cnt_ff, cnt_in;

   lers_pkg::req_word_type word;
   logic accept, take;

   // window arithmetic
   lers_pkg::win_type half_s, pad_s, width_s, col_s;
   lers_pkg::win_type ls0, le0, rs0, re0;
   lers_pkg::win_type b_ls, b_le, b_rs, b_re;
   logic       b_ldone, b_rdone, b_lhv, b_rhv;
   logic [7:0] b_lhc, b_rhc, b_lc, b_rc;
   logic       is_lane, close;
   logic       nlhv, nrhv;
   logic [7:0] nlhc, nrhc;
   logic       left_emit, right_emit;
   lers_pkg::win_type l_s, l_e, r_s, r_e, r_edge;
   logic       l_below, r_above;
   logic [7:0] lc1, rc1;

   // result candidates and packed slots
   lers_pkg::rsp_word_type cand [lers_pkg::ResultSlots];
   lers_pkg::rsp_word_type slot [lers_pkg::ResultSlots];
   logic [2:0] cand_v;
   logic [1:0] n_res;

   assign word   = req_chan.data;
   assign take   = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_chan.data  = res_ff[0];

   // ---------------------------------------------------------------- config
   always_comb begin
      roi_left_in  = roi_left_ff;
      roi_width_in = roi_width_ff;
      pad_in       = pad_ff;
      thresh_in    = thresh_ff;
      min_in       = min_ff;
      if (csr_wr_en) begin
         unique case (lers_pkg::csr_index_type'(csr_index))
            lers_pkg::CSR_ROI_LEFT:   roi_left_in  = csr_wdata[7:0];
            lers_pkg::CSR_ROI_WIDTH:  roi_width_in = csr_wdata;
            lers_pkg::CSR_PAD_WIDTH:  pad_in       = csr_wdata[5:0];
            lers_pkg::CSR_THRESHOLD:  thresh_in    = csr_wdata[7:0];
            lers_pkg::CSR_MIN_POINTS: min_in       = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- scan
   always_comb begin
      half_s  = lers_pkg::win_type'({2'b00, roi_width_ff[8:1]});
      pad_s   = lers_pkg::win_type'({4'b0000, pad_ff});
      width_s = lers_pkg::win_type'({1'b0, roi_width_ff});
      col_s   = lers_pkg::win_type'({2'b00, word.column});

      ls0 = half_s - pad_s;
      le0 = lers_pkg::win_type'({2'b00, roi_left_ff}) + pad_s;
      rs0 = half_s + pad_s;
      re0 = width_s - 10'sd1 - pad_s;

      // frame start restarts from the registers before the pixel is used
      if (word.frame_start) begin
         b_ls = ls0;  b_le = le0;  b_rs = rs0;  b_re = re0;
         b_ldone = 1'b0;  b_rdone = 1'b0;
         b_lhv = 1'b0;  b_rhv = 1'b0;
         b_lhc = '0;  b_rhc = '0;
         b_lc = '0;  b_rc = '0;
      end else begin
         b_ls = ls_ff;  b_le = le_ff;  b_rs = rs_ff;  b_re = re_ff;
         b_ldone = ldone_ff;  b_rdone = rdone_ff;
         b_lhv = lhv_ff;  b_rhv = rhv_ff;
         b_lhc = lhc_ff;  b_rhc = rhc_ff;
         b_lc = lc_ff;  b_rc = rc_ff;
      end

      is_lane = (word.pixel_value > thresh_ff) &&
                ({1'b0, word.column} < 9'(lers_pkg::ColumnLimit));

      // left keeps the last hit, right the first
      nlhv = b_lhv;
      nlhc = b_lhc;
      if (is_lane && !b_ldone && (col_s >= b_le) && (col_s <= b_ls)) begin
         nlhv = 1'b1;
         nlhc = word.column;
      end
      nrhv = b_rhv;
      nrhc = b_rhc;
      if (is_lane && !b_rdone && !b_rhv && (col_s >= b_rs) && (col_s <= b_re)) begin
         nrhv = 1'b1;
         nrhc = word.column;
      end

      close      = word.row_end || word.frame_end;
      left_emit  = close && nlhv;
      right_emit = close && nrhv;

      // re-centre around the hit, clamped to the centre limit and edges
      l_s     = lers_pkg::win_type'({2'b00, nlhc}) + pad_s;
      l_e     = lers_pkg::win_type'({2'b00, nlhc}) - pad_s;
      l_below = (l_s < ls0);
      r_s     = lers_pkg::win_type'({2'b00, nrhc}) - pad_s;
      r_e     = lers_pkg::win_type'({2'b00, nrhc}) + pad_s;
      r_edge  = width_s - 10'sd1;
      r_above = (r_s > rs0);

      lc1 = b_lc + 8'((left_emit && (b_lc != 8'hFF)) ? 1 : 0);
      rc1 = b_rc + 8'((right_emit && (b_rc != 8'hFF)) ? 1 : 0);

      ls_in = b_ls;  le_in = b_le;  ldone_in = b_ldone;
      rs_in = b_rs;  re_in = b_re;  rdone_in = b_rdone;
      if (left_emit) begin
         ls_in    = l_below ? l_s : ls0;
         le_in    = (l_e > 10'sd0) ? l_e : 10'sd0;
         ldone_in = b_ldone || !l_below;
      end
      if (right_emit) begin
         rs_in    = r_above ? r_s : rs0;
         re_in    = (r_e < r_edge) ? r_e : r_edge;
         rdone_in = b_rdone || !r_above;
      end
      lhv_in = close ? 1'b0 : nlhv;
      lhc_in = close ? 8'd0 : nlhc;
      rhv_in = close ? 1'b0 : nrhv;
      rhc_in = close ? 8'd0 : nrhc;
      lc_in  = lc1;
      rc_in  = rc1;
   end

   // ---------------------------------------------------------------- results
   always_comb begin
      logic [1:0] idx;
      idx = 2'd0;

      cand[0].kind          = lers_pkg::KIND_LEFT;
      cand[0].edge_column   = nlhc;
      cand[0].edge_row      = word.row;
      cand[0].left_total    = lc1;
      cand[0].right_total   = b_rc;
      cand[0].enough_points = (lc1 >= min_ff) || (b_rc >= min_ff);
      cand[0].last          = 1'b0;

      cand[1].kind          = lers_pkg::KIND_RIGHT;
      cand[1].edge_column   = nrhc;
      cand[1].edge_row      = word.row;
      cand[1].left_total    = lc1;
      cand[1].right_total   = rc1;
      cand[1].enough_points = (lc1 >= min_ff) || (rc1 >= min_ff);
      cand[1].last          = 1'b0;

      cand[2].kind          = lers_pkg::KIND_SUMMARY;
      cand[2].edge_column   = '0;
      cand[2].edge_row      = '0;
      cand[2].left_total    = lc1;
      cand[2].right_total   = rc1;
      cand[2].enough_points = (lc1 >= min_ff) || (rc1 >= min_ff);
      cand[2].last          = 1'b0;

      cand_v = {word.frame_end, right_emit, left_emit};

      for (int i = 0; i < lers_pkg::ResultSlots; i++) begin
         slot[i] = cand[i];
      end
      for (int i = 0; i < lers_pkg::ResultSlots; i++) begin
         if (cand_v[i]) begin
            slot[idx] = cand[i];
            idx       = idx + 2'd1;
         end
      end
      n_res = idx;
      if (n_res != 2'd0) begin
         slot[n_res - 2'd1].last = 1'b1;
      end
   end

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         res_in = slot;
         cnt_in = n_res;
      end else if (take) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         roi_left_ff  <= lers_pkg::RoiLeftReset;
         roi_width_ff <= lers_pkg::RoiWidthReset;
         pad_ff       <= lers_pkg::PadWidthReset;
         thresh_ff    <= lers_pkg::ThresholdReset;
         min_ff       <= lers_pkg::MinPointsReset;
      end else begin
         roi_left_ff  <= roi_left_in;
         roi_width_ff <= roi_width_in;
         pad_ff       <= pad_in;
         thresh_ff    <= thresh_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff    <= lers_pkg::LeftStartReset;
         le_ff    <= lers_pkg::LeftEndReset;
         rs_ff    <= lers_pkg::RightStartReset;
         re_ff    <= lers_pkg::RightEndReset;
         ldone_ff <= 1'b0;
         rdone_ff <= 1'b0;
         lhv_ff   <= 1'b0;
         rhv_ff   <= 1'b0;
         lhc_ff   <= '0;
         rhc_ff   <= '0;
         lc_ff    <= '0;
         rc_ff    <= '0;
      end else if (accept) begin
         ls_ff    <= ls_in;
         le_ff    <= le_in;
         rs_ff    <= rs_in;
         re_ff    <= re_in;
         ldone_ff <= ldone_in;
         rdone_ff <= rdone_in;
         lhv_ff   <= lhv_in;
         rhv_ff   <= rhv_in;
         lhc_ff   <= lhc_in;
         rhc_ff   <= rhc_in;
         lc_ff    <= lc_in;
         rc_ff    <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // ---------------------------------------------------------------- checks
   `LERS_ASSERT_IMPL(a_single_left_is_last, clock, reset, cnt_ff == 2'd1, res_ff[0].last, "lone result word not marked last")
   `LERS_ASSERT_IMPL(a_summary_fields, clock, reset, rsp_chan.valid && (res_ff[0].kind == lers_pkg::KIND_SUMMARY), (res_ff[0].edge_column == 8'd0) && (res_ff[0].edge_row == 8'd0) && res_ff[0].last, "summary word malformed")
   `LERS_ASSERT_NEXT(a_left_done_sticks, clock, reset, ldone_ff && !(accept && word.frame_start), ldone_ff, "left side resumed within a frame")
   `LERS_ASSERT_NEXT(a_right_done_sticks, clock, reset, rdone_ff && !(accept && word.frame_start), rdone_ff, "right side resumed within a frame")

endmodule

`default_nettype wire

@@ dv/lane_edge_row_scanner_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lane_edge_row_scanner_unit: directed pixel table, then random frames.
// Depends on lers_pkg, lers_word_if and the unit RTL; results are checked against a local predictor or typed-in words.

module lane_edge_row_scanner_unit_tb;

   typedef struct {
      lers_pkg::req_word_type word;
      int                     typed_n;   // results typed in below, -1 means use the predictor
   } table_row_type;

   typedef struct packed {
      logic [7:0] roi_left;
      logic [8:0] roi_width;
      logic [5:0] pad_width;
      logic [7:0] threshold;
      logic [7:0] min_points;
   } csr_set_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   lers_pkg::csr_index_type csr_index = lers_pkg::CSR_ROI_LEFT;
   logic [8:0]              csr_wdata = '0;

   lers_word_if #(.word_type(lers_pkg::req_word_type)) req_chan ();
   lers_word_if #(.word_type(lers_pkg::rsp_word_type)) rsp_chan ();

   lane_edge_row_scanner_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   logic [7:0] cfg_roi_left   = lers_pkg::RoiLeftReset;
   logic [8:0] cfg_roi_width  = lers_pkg::RoiWidthReset;
   logic [5:0] cfg_pad        = lers_pkg::PadWidthReset;
   logic [7:0] cfg_threshold  = lers_pkg::ThresholdReset;
   logic [7:0] cfg_min_points = lers_pkg::MinPointsReset;

   lers_pkg::win_type lwin_start, lwin_end, rwin_start, rwin_end;
   logic       left_stop, right_stop, left_found, right_found;
   logic [7:0] left_col, right_col, left_pts, right_pts;

   lers_pkg::rsp_word_type edge_queue[$];   // expected result words, oldest first
   int unsigned  mismatches = 0;

   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit rx_hold_off = 1'b0;

   function automatic int half_width();
      return int'(cfg_roi_width >> 1);
   endfunction

   function automatic void open_frame();
      lwin_start  = lers_pkg::win_type'(half_width() - int'(cfg_pad));
      lwin_end    = lers_pkg::win_type'(int'(cfg_roi_left) + int'(cfg_pad));
      rwin_start  = lers_pkg::win_type'(half_width() + int'(cfg_pad));
      rwin_end    = lers_pkg::win_type'(int'(cfg_roi_width) - 1 - int'(cfg_pad));
      left_stop   = 1'b0;
      right_stop  = 1'b0;
      left_found  = 1'b0;
      right_found = 1'b0;
      left_col    = '0;
      right_col   = '0;
      left_pts    = '0;
      right_pts   = '0;
   endfunction

   function automatic void apply_csr(lers_pkg::csr_index_type idx, logic [8:0] v);
      case (idx)
         lers_pkg::CSR_ROI_LEFT:   cfg_roi_left = v[7:0];
         lers_pkg::CSR_ROI_WIDTH:  cfg_roi_width = v;
         lers_pkg::CSR_PAD_WIDTH:  cfg_pad = v[5:0];
         lers_pkg::CSR_THRESHOLD:  cfg_threshold = v[7:0];
         lers_pkg::CSR_MIN_POINTS: cfg_min_points = v[7:0];
         default: ;
      endcase
   endfunction

   function automatic lers_pkg::rsp_word_type edge_word(lers_pkg::kind_type kind,
                                                        logic [7:0] col, logic [7:0] row);
      lers_pkg::rsp_word_type r;
      r.kind          = kind;
      r.edge_column   = col;
      r.edge_row      = row;
      r.left_total    = left_pts;
      r.right_total   = right_pts;
      r.enough_points = (left_pts >= cfg_min_points) || (right_pts >= cfg_min_points);
      r.last          = 1'b0;
      return r;
   endfunction

   // one pixel word in, zero to three result words out
   function automatic int scan_pixel(input lers_pkg::req_word_type w,
                                     output lers_pkg::rsp_word_type res[3]);
      int col, half, pad, s, e, lim, edge_lim, n;
      col = int'(w.column);
      n = 0;
      if (w.frame_start)
         open_frame();
      if (w.pixel_value > cfg_threshold && col < int'(lers_pkg::ColumnLimit)) begin
         if (!left_stop && col >= int'(lwin_end) && col <= int'(lwin_start)) begin
            left_col   = w.column;
            left_found = 1'b1;
         end
         if (!right_stop && !right_found && col >= int'(rwin_start) &&
             col <= int'(rwin_end)) begin
            right_col   = w.column;
            right_found = 1'b1;
         end
      end
      if (w.row_end || w.frame_end) begin
         half = half_width();
         pad  = int'(cfg_pad);
         if (left_found) begin
            s   = int'(left_col) + pad;
            e   = int'(left_col) - pad;
            lim = half - pad;
            lwin_start = lers_pkg::win_type'((s < lim) ? s : lim);
            lwin_end   = lers_pkg::win_type'((e > 0) ? e : 0);
            // snapped to the center limit: this side is finished for the frame
            if (int'(lwin_start) == lim)
               left_stop = 1'b1;
            if (left_pts != 8'd255)
               left_pts++;
            res[n] = edge_word(lers_pkg::KIND_LEFT, left_col, w.row);
            n++;
         end
         if (right_found) begin
            s        = int'(right_col) - pad;
            e        = int'(right_col) + pad;
            lim      = half + pad;
            edge_lim = int'(cfg_roi_width) - 1;
            rwin_start = lers_pkg::win_type'((s > lim) ? s : lim);
            rwin_end   = lers_pkg::win_type'((e < edge_lim) ? e : edge_lim);
            if (int'(rwin_start) == lim)
               right_stop = 1'b1;
            if (right_pts != 8'd255)
               right_pts++;
            res[n] = edge_word(lers_pkg::KIND_RIGHT, right_col, w.row);
            n++;
         end
         left_found  = 1'b0;
         right_found = 1'b0;
         left_col    = '0;
         right_col   = '0;
      end
      if (w.frame_end) begin
         res[n] = edge_word(lers_pkg::KIND_SUMMARY, 8'd0, 8'd0);
         n++;
      end
      if (n > 0)
         res[n - 1].last = 1'b1;
      return n;
   endfunction

   // ---------------------------------------------------------------- directed part
   table_row_type pixel_table[17] = '{
      '{'{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0},  0},   // left of both windows
      '{'{8'd129, 8'd10,  8'd0,   1'b0, 1'b0, 1'b0},  0},   // left window end, just over threshold
      '{'{8'd128, 8'd138, 8'd0,   1'b0, 1'b0, 1'b0},  0},   // equal to threshold is not lane
      '{'{8'd200, 8'd245, 8'd0,   1'b1, 1'b0, 1'b0},  2},
      '{'{8'd255, 8'd255, 8'd1,   1'b1, 1'b0, 1'b1},  2},
      '{'{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1},  1},   // empty frame in a single word
      '{'{8'd255, 8'd118, 8'd5,   1'b0, 1'b1, 1'b0}, -1},
      '{'{8'd255, 8'd100, 8'd5,   1'b0, 1'b0, 1'b0}, -1},
      '{'{8'd255, 8'd200, 8'd5,   1'b0, 1'b0, 1'b0}, -1},
      '{'{8'd255, 8'd150, 8'd5,   1'b1, 1'b0, 1'b0}, -1},   // out of order, right keeps first
      '{'{8'd255, 8'd118, 8'd6,   1'b0, 1'b0, 1'b0}, -1},
      '{'{8'd255, 8'd105, 8'd6,   1'b1, 1'b0, 1'b0}, -1},   // left window narrowed to 90..110, only 105 hits
      '{'{8'd0,   8'd255, 8'd7,   1'b0, 1'b0, 1'b1}, -1},   // frame end closes the row
      '{'{8'd255, 8'd138, 8'd255, 1'b1, 1'b1, 1'b0}, -1},   // right snaps to center limit
      '{'{8'd255, 8'd200, 8'd254, 1'b1, 1'b0, 1'b0}, -1},
      '{'{8'd255, 8'd118, 8'd253, 1'b1, 1'b0, 1'b1}, -1},   // left snaps to center limit
      '{'{8'd255, 8'd50,  8'd0,   1'b1, 1'b0, 1'b1}, -1}    // both sides finished
   };

   lers_pkg::rsp_word_type typed_rsp[$] = '{
      '{lers_pkg::KIND_LEFT,    8'd10,  8'd0, 8'd1, 8'd0, 1'b0, 1'b0},
      '{lers_pkg::KIND_RIGHT,   8'd245, 8'd0, 8'd1, 8'd1, 1'b0, 1'b1},
      '{lers_pkg::KIND_RIGHT,   8'd255, 8'd1, 8'd1, 8'd2, 1'b0, 1'b0},
      '{lers_pkg::KIND_SUMMARY, 8'd0,   8'd0, 8'd1, 8'd2, 1'b0, 1'b1},
      '{lers_pkg::KIND_SUMMARY, 8'd0,   8'd0, 8'd0, 8'd0, 1'b0, 1'b1}
   };

   csr_set_type csr_sets[7] = '{
      '{8'd0,   9'd256, 6'd10, 8'd128, 8'd10},
      '{8'd20,  9'd200, 6'd5,  8'd100, 8'd3},
      '{8'd255, 9'd256, 6'd63, 8'd0,   8'd0},
      '{8'd0,   9'd1,   6'd0,  8'd254, 8'd255},
      '{8'd40,  9'd511, 6'd30, 8'd60,  8'd5},
      '{8'd7,   9'd0,   6'd12, 8'd200, 8'd1},
      '{8'd64,  9'd160, 6'd8,  8'd90,  8'd4}
   };

   lers_pkg::csr_index_type csr_order[5] = '{
      lers_pkg::CSR_ROI_LEFT, lers_pkg::CSR_ROI_WIDTH, lers_pkg::CSR_PAD_WIDTH,
      lers_pkg::CSR_THRESHOLD, lers_pkg::CSR_MIN_POINTS};

   // mostly no gap, some short, a few long
   function automatic int idle_len(bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(25, 8);
   endfunction

   function automatic logic [7:0] lane_level();
      if (cfg_threshold == 8'd255)
         return 8'd255;
      return 8'($urandom_range(255, int'(cfg_threshold) + 1));
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input lers_pkg::req_word_type w, input int typed_n);
      lers_pkg::rsp_word_type res[3];
      int n, gap;
      gap = idle_len(tx_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do @(posedge clock); while (!req_chan.ready);
      n = scan_pixel(w, res);
      if (typed_n < 0) begin
         for (int i = 0; i < n; i++)
            edge_queue = {edge_queue, res[i]};
      end else begin
         repeat (typed_n) begin
            edge_queue = {edge_queue, typed_rsp[0]};
            typed_rsp.delete(0);
         end
      end
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (edge_queue.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_regs(input csr_set_type s);
      logic [8:0] vals[5];
      vals = '{9'(s.roi_left), s.roi_width, 9'(s.pad_width), 9'(s.threshold), 9'(s.min_points)};
      foreach (csr_order[i]) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_order[i];
         csr_wdata <= vals[i];
         apply_csr(csr_order[i], vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // frames of a few rows; each row has a pixel near each lane plus stray pixels
   task automatic random_frames(input int budget, input bit keep_frame);
      int lpos, rpos, rhi, rows, base;
      int cols[$];
      lers_pkg::req_word_type w;
      bit noise, cut_row_end, start_due, last_col, last_row;
      start_due = !keep_frame;
      while (budget > 0) begin
         rows = $urandom_range(8, 2);
         base = $urandom_range(255);
         rhi  = int'(cfg_roi_width) - 1;
         rhi  = (rhi < 0) ? 0 : ((rhi > 255) ? 255 : rhi);
         lpos = $urandom_range(int'(cfg_roi_left), half_width());
         rpos = $urandom_range(half_width(), rhi);
         cut_row_end = ($urandom_range(9) == 0);
         for (int r = 0; r < rows && budget > 0; r++) begin
            lpos = lpos + int'($urandom_range(6)) - 3;
            rpos = rpos + int'($urandom_range(6)) - 3;
            lpos = (lpos < 0) ? 0 : ((lpos > 255) ? 255 : lpos);
            rpos = (rpos < 0) ? 0 : ((rpos > 255) ? 255 : rpos);
            cols = {lpos, rpos};
            repeat ($urandom_range(3)) cols = {cols, int'($urandom_range(255))};
            noise = ($urandom_range(9) == 0);
            if (noise)
               cols.shuffle();
            else
               cols.sort();
            last_row = (r == rows - 1);
            foreach (cols[k]) begin
               last_col = (k == cols.size() - 1);
               w.pixel_value = ($urandom_range(9) < 7) ? lane_level() : 8'($urandom_range(255));
               w.column      = 8'(cols[k]);
               w.row         = 8'(base - r);
               w.frame_start = start_due && (r == 0) && (k == 0);
               w.row_end     = last_col && !(last_row && cut_row_end);
               w.frame_end   = last_col && last_row;
               if (noise) begin
                  w.row_end     = 1'($urandom_range(1));
                  w.frame_start = ($urandom_range(7) == 0);
                  w.frame_end   = ($urandom_range(15) == 0);
               end
               send_word(w, -1);
               budget--;
            end
         end
         start_due = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- result side
   initial begin : rsp_pacer
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rx_hold_off) begin
            // long hold-off so the result bank fills and the input stalls
            rsp_chan.ready <= 1'b0;
            repeat (40) @(negedge clock);
            rx_hold_off = 1'b0;
         end else if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall = idle_len(rx_steady);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      lers_pkg::rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (edge_queue.size() == 0) begin
            $error("result word with nothing expected: kind %0d column %0d row %0d",
                   rsp_chan.data.kind, rsp_chan.data.edge_column, rsp_chan.data.edge_row);
            mismatches++;
         end else begin
            want = edge_queue[0];
            edge_queue.delete(0);
            check_field("kind", want.kind, rsp_chan.data.kind);
            check_field("edge_column", want.edge_column, rsp_chan.data.edge_column);
            check_field("edge_row", want.edge_row, rsp_chan.data.edge_row);
            check_field("left_total", want.left_total, rsp_chan.data.left_total);
            check_field("right_total", want.right_total, rsp_chan.data.right_total);
            check_field("enough_points", want.enough_points, rsp_chan.data.enough_points);
            check_field("last", want.last, rsp_chan.data.last);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      open_frame();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (pixel_table[i])
         send_word(pixel_table[i].word, pixel_table[i].typed_n);

      for (int p = 0; p < 7; p++) begin
         quiesce();
         write_regs(csr_sets[p]);
         tx_steady   = (p == 1 || p == 3);
         rx_steady   = (p == 3);
         rx_hold_off = (p == 1);
         // odd sets pick up a frame the previous set may have left open
         random_frames(30, p % 2 == 1);
      end

      quiesce();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && edge_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
